### design/sha1_stream_hasher_macros.svh
// Assertion macros for the SHA-1 stream hasher modules.
// No dependencies; included by shsh_ctrl, which carries concurrent checks.
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

// same-cycle implication
`define SHSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/shsh_pkg.sv
// Shared types and constants for the SHA-1 stream hasher.
// No dependencies; imported by the controller, datapath and top level.
package shsh_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned BLK_BITS  = 512;

    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LEN_PREV  = LEN_POS - 6'd1;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [7:0] PAD_MARK  = 8'h80;

    localparam logic [6:0] ROUND_20   = 7'd20;
    localparam logic [6:0] ROUND_40   = 7'd40;
    localparam logic [6:0] ROUND_60   = 7'd60;
    localparam logic [6:0] LAST_ROUND = 7'd79;

    localparam logic [2:0] LAST_WORD = 3'd4;

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    localparam t_word H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic      load;
        t_byte_sel sel;
        logic      work_init;
        logic      rnd_step;
        logic [6:0] round;
        logic      chain_add;
        logic      chain_init;
        logic [2:0] word_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_dp_status;

endpackage

### design/shsh_datapath.sv
// Datapath: byte block shift line doubling as message schedule, round unit,
// chaining words and bit counter. Depends on shsh_pkg; driven by shsh_ctrl.
module shsh_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  shsh_pkg::t_dp_cmd    i_cmd,
    input  logic [7:0]           i_data_byte,
    output shsh_pkg::t_dp_status o_status,
    output shsh_pkg::t_word      o_digest_word
);
    import shsh_pkg::*;

    logic [BLK_BITS-1:0] r_blk;
    t_word               r_h [NUM_WORDS];
    t_word               r_a, r_b, r_c, r_d, r_e;
    logic [5:0]          r_fill;
    logic [63:0]         r_bit_count;

    logic [7:0] s_byte;
    logic [5:0] s_len_shift;
    t_word      s_w0, s_w2, s_w8, s_w13, s_wx, s_w_new;
    t_word      s_f, s_k, s_tmp;

    assign s_len_shift = {~r_fill[2:0], 3'b000};

    always_comb begin
        unique case (i_cmd.sel)
            SEL_DATA: s_byte = i_data_byte;
            SEL_MARK: s_byte = PAD_MARK;
            SEL_ZERO: s_byte = 8'h00;
            SEL_LEN:  s_byte = 8'(r_bit_count >> s_len_shift);
            default:  s_byte = 8'h00;
        endcase
    end

    // word i of the window sits at bits [511-32i -: 32]
    assign s_w0    = r_blk[BLK_BITS-1 -: 32];
    assign s_w2    = r_blk[BLK_BITS-1-64 -: 32];
    assign s_w8    = r_blk[BLK_BITS-1-256 -: 32];
    assign s_w13   = r_blk[BLK_BITS-1-416 -: 32];
    assign s_wx    = s_w13 ^ s_w8 ^ s_w2 ^ s_w0;
    assign s_w_new = {s_wx[30:0], s_wx[31]};

    always_comb begin
        if (i_cmd.round < ROUND_20) begin
            s_f = r_d ^ (r_b & (r_c ^ r_d));
            s_k = K0;
        end else if (i_cmd.round < ROUND_40) begin
            s_f = r_b ^ r_c ^ r_d;
            s_k = K1;
        end else if (i_cmd.round < ROUND_60) begin
            s_f = (r_b & r_c) | (r_d & (r_b | r_c));
            s_k = K2;
        end else begin
            s_f = r_b ^ r_c ^ r_d;
            s_k = K3;
        end
    end

    assign s_tmp = {r_a[26:0], r_a[31:27]} + s_f + r_e + s_k + s_w0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_blk <= {r_blk[BLK_BITS-9:0], s_byte};
        end else if (i_cmd.rnd_step) begin
            r_blk <= {r_blk[BLK_BITS-33:0], s_w_new};
        end
        if (i_cmd.work_init) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.rnd_step) begin
            r_a <= s_tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h         <= H_INIT;
            r_fill      <= '0;
            r_bit_count <= '0;
        end else begin
            if (i_cmd.load) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.chain_init) begin
                r_h         <= H_INIT;
                r_bit_count <= '0;
            end else begin
                if (i_cmd.load && (i_cmd.sel == SEL_DATA)) begin
                    r_bit_count <= r_bit_count + 64'd8;
                end
                if (i_cmd.chain_add) begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                end
            end
        end
    end

    assign o_status.fill = r_fill;
    assign o_digest_word = r_h[i_cmd.word_idx];

endmodule

### design/shsh_ctrl.sv
// Controller FSM: absorb, padding sequence, 80-round compression, digest output.
// Depends on shsh_pkg and sha1_stream_hasher_macros.svh; drives shsh_datapath.
`include "sha1_stream_hasher_macros.svh"

module shsh_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_action,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_word_index,
    output logic                 o_last_word,
    input  shsh_pkg::t_dp_status i_status,
    output shsh_pkg::t_dp_cmd    o_cmd
);
    import shsh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_ZERO1,
        S_ZERO2,
        S_LEN,
        S_COMP,
        S_ADD,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        R_IDLE,
        R_PAD,
        R_EMIT
    } t_ret;

    t_state     r_state, n_state;
    t_ret       r_ret, n_ret;
    logic [6:0] r_round;
    logic [2:0] r_widx;
    logic       s_out_fire;

    assign s_out_fire = (r_state == S_EMIT) && i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.sel      = SEL_ZERO;
        o_cmd.round    = r_round;
        o_cmd.word_idx = r_widx;
        n_state        = r_state;
        n_ret          = r_ret;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_action) begin
                        n_state = S_MARK;
                    end else begin
                        o_cmd.load = 1'b1;
                        o_cmd.sel  = SEL_DATA;
                        if (i_status.fill == FILL_LAST) begin
                            o_cmd.work_init = 1'b1;
                            n_state         = S_COMP;
                            n_ret           = R_IDLE;
                        end
                    end
                end
            end
            S_MARK: begin
                o_cmd.load = 1'b1;
                o_cmd.sel  = SEL_MARK;
                if (i_status.fill == FILL_LAST) begin
                    o_cmd.work_init = 1'b1;
                    n_state         = S_COMP;
                    n_ret           = R_PAD;
                end else if (i_status.fill >= LEN_POS) begin
                    n_state = S_ZERO1;
                end else if (i_status.fill == LEN_PREV) begin
                    n_state = S_LEN;
                end else begin
                    n_state = S_ZERO2;
                end
            end
            S_ZERO1: begin
                o_cmd.load = 1'b1;
                if (i_status.fill == FILL_LAST) begin
                    o_cmd.work_init = 1'b1;
                    n_state         = S_COMP;
                    n_ret           = R_PAD;
                end
            end
            S_ZERO2: begin
                o_cmd.load = 1'b1;
                if (i_status.fill == LEN_PREV) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.load = 1'b1;
                o_cmd.sel  = SEL_LEN;
                if (i_status.fill == FILL_LAST) begin
                    o_cmd.work_init = 1'b1;
                    n_state         = S_COMP;
                    n_ret           = R_EMIT;
                end
            end
            S_COMP: begin
                o_cmd.rnd_step = 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.chain_add = 1'b1;
                unique case (r_ret)
                    R_IDLE:  n_state = S_IDLE;
                    R_PAD:   n_state = S_ZERO2;
                    R_EMIT:  n_state = S_EMIT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (i_out_ready && (r_widx == LAST_WORD)) begin
                    o_cmd.chain_init = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= R_IDLE;
            r_round <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= (r_state == S_COMP) ? r_round + 7'd1 : '0;
            if (s_out_fire) begin
                r_widx <= (r_widx == LAST_WORD) ? 3'd0 : r_widx + 3'd1;
            end
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_EMIT);
    assign o_word_index = r_widx;
    assign o_last_word  = (r_widx == LAST_WORD);

    `SHSH_ASSERT_IMP(a_round_range, i_clk, i_rst_n, r_state == S_COMP, r_round <= LAST_ROUND, "round counter past last round")
    `SHSH_ASSERT_IMP(a_len_fill, i_clk, i_rst_n, r_state == S_LEN, i_status.fill >= LEN_POS, "length bytes outside tail of block")
    `SHSH_ASSERT_NXT(a_emit_done, i_clk, i_rst_n, s_out_fire && (r_widx == LAST_WORD), (r_state == S_IDLE) && (r_widx == 3'd0) && (i_status.fill == 6'd0), "digest end did not restart")
    `SHSH_ASSERT_IMP(a_idle_widx, i_clk, i_rst_n, r_state != S_EMIT, r_widx == 3'd0, "word index left nonzero outside output")

endmodule

### design/sha1_stream_hasher.sv
// Top level of the SHA-1 stream hasher: stream ports, controller and datapath.
// Depends on shsh_pkg, shsh_ctrl and shsh_datapath.
//
//  channel   dir  tdata              tuser          tlast
//  s_axis    in   data_byte[7:0]     action[0]      -
//  m_axis    out  digest_word[31:0]  word_index[2:0] last_word
//
// Absorb: one byte per cycle while input is ready; the 64th byte of a block
// starts 80 rounds on one round unit, then the chaining add, and stalls input.
// Finish: pad mark, zero bytes and length bytes, with one extra block when
// fill >= 56, then compression and 5 output items; input is stalled meanwhile.
// Reset is synchronous; output stalls hold the digest word steady.
module sha1_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] word_index
    output logic        o_m_axis_tlast
);
    import shsh_pkg::*;

    t_dp_cmd    s_cmd;
    t_dp_status s_status;

    shsh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_action  (i_s_axis_tuser),
        .o_in_ready   (o_s_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_word_index (o_m_axis_tuser),
        .o_last_word  (o_m_axis_tlast),
        .i_status     (s_status),
        .o_cmd        (s_cmd)
    );

    shsh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .i_data_byte   (i_s_axis_tdata),
        .o_status      (s_status),
        .o_digest_word (o_m_axis_tdata)
    );

endmodule

### tb/tb_sha1_stream_hasher.sv
// Self-checking testbench for sha1_stream_hasher: byte items in, five digest words out.
// A directed table runs first, then random messages; an in-bench SHA-1 model predicts
// each untyped digest. Depends on shsh_pkg and the sha1_stream_hasher RTL.
module tb_sha1_stream_hasher;
    import shsh_pkg::*;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;
    localparam int   HOLD_CYCLES = 3000;
    localparam int   SETTLE_CYCLES = 300;
    localparam int   RAND_ITEMS = 140;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_item;

    typedef struct packed {
        logic         act;
        logic [7:0]   value;
        logic [7:0]   reps;
        logic         typed;
        logic [159:0] dig;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;
    logic        i_s_axis_tuser = ACT_ABSORB;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    logic        hold_req = 1'b0;
    int          mismatch_cnt = 0;
    int          burst_left = 0;
    t_digest_item pending_digest_q[$];

    // hash state of the predictor
    logic [31:0] chain_h [5];
    logic [7:0]  msg_blk [64];
    logic [5:0]  fill_pos;
    logic [63:0] msg_bits;

    localparam int N_ROWS = 17;
    t_dir_row dir_rows [N_ROWS] = '{
        '{ACT_FINISH, 8'h00, 8'd1,   1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
        '{ACT_ABSORB, 8'h61, 8'd1,   1'b0, 160'h0},
        '{ACT_ABSORB, 8'h62, 8'd1,   1'b0, 160'h0},
        '{ACT_ABSORB, 8'h63, 8'd1,   1'b0, 160'h0},
        '{ACT_FINISH, 8'h00, 8'd1,   1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
        '{ACT_ABSORB, 8'h00, 8'd1,   1'b0, 160'h0},
        '{ACT_ABSORB, 8'hFF, 8'd1,   1'b0, 160'h0},
        '{ACT_FINISH, 8'h00, 8'd1,   1'b0, 160'h0},
        '{ACT_ABSORB, 8'h5A, 8'd55,  1'b0, 160'h0},   // pad fits: no extra block
        '{ACT_FINISH, 8'h00, 8'd1,   1'b0, 160'h0},
        '{ACT_ABSORB, 8'hFF, 8'd56,  1'b0, 160'h0},   // length spills: extra block
        '{ACT_FINISH, 8'h00, 8'd1,   1'b0, 160'h0},
        '{ACT_ABSORB, 8'h00, 8'd63,  1'b0, 160'h0},
        '{ACT_FINISH, 8'h00, 8'd1,   1'b0, 160'h0},
        '{ACT_ABSORB, 8'hA5, 8'd128, 1'b0, 160'h0},   // two full blocks, finish at fill 0
        '{ACT_FINISH, 8'h00, 8'd1,   1'b0, 160'h0},
        '{ACT_FINISH, 8'hFF, 8'd1,   1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709}
    };

    sha1_stream_hasher u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),    // [7:0] data_byte
        .i_s_axis_tuser  (i_s_axis_tuser),    // [0] action
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),    // [31:0] digest_word
        .o_m_axis_tuser  (o_m_axis_tuser),    // [2:0] word_index
        .o_m_axis_tlast  (o_m_axis_tlast)     // last_word
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void sha_restart();
        for (int i = 0; i < 5; i++) chain_h[i] = H_INIT[i];
        fill_pos = '0;
        msg_bits = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, x, tmp;
        int s;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_blk[4*t], msg_blk[4*t+1], msg_blk[4*t+2], msg_blk[4*t+3]};
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (int t = 0; t < 80; t++) begin
            s = t & 15;
            if (t >= 16) begin
                x = w[(s+13)&15] ^ w[(s+8)&15] ^ w[(s+2)&15] ^ w[s];
                w[s] = {x[30:0], x[31]};
            end
            if (t < 20) begin
                f = d ^ (b & (c ^ d)); k = K0;
            end else if (t < 40) begin
                f = b ^ c ^ d; k = K1;
            end else if (t < 60) begin
                f = (b & c) | (d & (b | c)); k = K2;
            end else begin
                f = b ^ c ^ d; k = K3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w[s];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = tmp;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
    endfunction

    function automatic void sha_absorb(input logic [7:0] value);
        msg_blk[fill_pos] = value;
        msg_bits += 64'd8;
        fill_pos += 6'd1;
        if (fill_pos == 6'd0) sha_compress();
    endfunction

    function automatic logic [159:0] sha_finish();
        logic [159:0] dig;
        msg_blk[fill_pos] = PAD_MARK;
        for (int i = int'(fill_pos) + 1; i < 64; i++) msg_blk[i] = 8'h00;
        if (fill_pos >= LEN_POS) begin
            sha_compress();
            for (int i = 0; i < int'(LEN_POS); i++) msg_blk[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) msg_blk[int'(LEN_POS) + i] = msg_bits[63 - 8*i -: 8];
        sha_compress();
        dig = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
        sha_restart();
        return dig;
    endfunction

    // drive one item, wait for the handshake, then update the prediction
    task automatic send_item(input logic act, input logic [7:0] value,
                             input logic typed, input logic [159:0] typed_dig);
        logic [159:0] dig;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= act;
        i_s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (act == ACT_ABSORB) begin
            sha_absorb(value);
        end else begin
            dig = sha_finish();
            if (typed) dig = typed_dig;
            for (int i = 0; i < 5; i++)
                pending_digest_q.push_back('{dig[159 - 32*i -: 32], 3'(i),
                                             3'(i) == LAST_WORD});
        end
    endtask

    task automatic pace_sender();
        int r;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_s_axis_tvalid <= 1'b0;
            r = $urandom_range(0, 9);
            repeat ((r == 9) ? $urandom_range(10, 40) : $urandom_range(1, 6)) @(posedge i_clk);
            r = $urandom_range(0, 9);
            burst_left = (r < 2) ? $urandom_range(100, 250) : $urandom_range(0, 20);
        end
    endtask

    task automatic drain_digests();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_digest_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int n_items;
        int n_msgs;
        int msg_len;
        int r;
        t_dir_row row;
        n_items = 0;
        n_msgs = 0;
        sha_restart();
        for (int i = 0; i < 64; i++) msg_blk[i] = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_ROWS; n++) begin
            row = dir_rows[n];
            for (int j = 0; j < int'(row.reps); j++) begin
                send_item(row.act, row.value, row.typed, row.dig);
                pace_sender();
            end
        end
        drain_digests();

        while (n_items < RAND_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 5) msg_len = $urandom_range(0, 20);
            else if (r < 7) msg_len = $urandom_range(54, 65);
            else if (r < 8) msg_len = $urandom_range(118, 122);
            else if (r < 9) msg_len = $urandom_range(0, 140);
            else msg_len = 0;
            for (int j = 0; j < msg_len; j++) begin
                send_item(ACT_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 160'h0);
                pace_sender();
            end
            send_item(ACT_FINISH, 8'($urandom_range(0, 255)), 1'b0, 160'h0);
            n_items += msg_len + 1;
            n_msgs++;
            if (n_msgs == 1) begin
                hold_req <= 1'b1;
                burst_left = 60;
            end
            if (n_msgs % 7 == 0) drain_digests();
            else pace_sender();
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_digest_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // receiver: changing stall patterns plus one long hold-off
    initial begin
        int mode;
        int span;
        int tick;
        bit hold_done;
        tick = 0;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 250);
            for (int k = 0; k < span; k++) begin
                @(posedge i_clk);
                tick++;
                if (hold_req && !hold_done) begin
                    i_m_axis_tready <= 1'b0;
                    hold_done = 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end else begin
                    case (mode)
                        0: i_m_axis_tready <= 1'b1;
                        1: i_m_axis_tready <= ($urandom_range(0, 9) < 7);
                        2: i_m_axis_tready <= ($urandom_range(0, 9) < 3);
                        default: i_m_axis_tready <= (tick % 4 == 0);
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_digest_item exp_item;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_digest_q.size() == 0) begin
                $display("%0t: unexpected digest item: word %h index %0d last %b", $time,
                         o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                mismatch_cnt++;
            end else begin
                exp_item = pending_digest_q.pop_front();
                if (o_m_axis_tdata !== exp_item.word) begin
                    $display("%0t: digest_word expected %h actual %h", $time,
                             exp_item.word, o_m_axis_tdata);
                    mismatch_cnt++;
                end
                if (o_m_axis_tuser !== exp_item.idx) begin
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             exp_item.idx, o_m_axis_tuser);
                    mismatch_cnt++;
                end
                if (o_m_axis_tlast !== exp_item.last) begin
                    $display("%0t: last_word expected %b actual %b", $time,
                             exp_item.last, o_m_axis_tlast);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #10000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sha1_stream_hasher.f
+incdir+design
design/shsh_pkg.sv
design/shsh_datapath.sv
design/shsh_ctrl.sv
design/sha1_stream_hasher.sv
tb/tb_sha1_stream_hasher.sv
